// ===== design/multi_keyword_highlight_matcher_assert.svh =====
// Assertion macros for the keyword matcher. Both expect clk and rst_n in scope.
`ifndef MULTI_KEYWORD_HIGHLIGHT_MATCHER_ASSERT_SVH
`define MULTI_KEYWORD_HIGHLIGHT_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define MKHM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`define MKHM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);
`else
`define MKHM_ASSERT_NEXT(lbl, pre, post, msg)
`define MKHM_ASSERT_ALWAYS(lbl, expr, msg)
`endif
`endif

// ===== design/mkhm_pkg.sv =====
package mkhm_pkg;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam int RULE_SLOTS = 4;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;
  localparam int CTL_W      = 7;

  // control register layout
  localparam int CTL_LEN_LSB = 0;
  localparam int CTL_LEN_MSB = 3;
  localparam int CTL_EN_BIT  = 4;
  localparam int CTL_CS_BIT  = 5;
  localparam int CTL_WW_BIT  = 6;

  // low address bit of the register index: keyword or control
  localparam logic REG_SEL_KEYWORD = 1'b0;
  localparam logic REG_SEL_CONTROL = 1'b1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t data;
    logic  occ;
  } cell_t;

  typedef struct packed {
    byte_t data;
    byte_t lower;
    logic  space;
    logic  occ;
  } cell_view_t;

  function automatic byte_t lower_ascii(input byte_t b);
    byte_t r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  function automatic logic byte_match(input byte_t t, input byte_t t_low, input byte_t k,
                                      input logic cs);
    byte_t k_low;
    k_low = lower_ascii(k);
    return cs ? (t == k) : (t_low == k_low);
  endfunction

endpackage

// ===== design/mkhm_cell.sv =====
module mkhm_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 clear,
  input  mkhm_pkg::cell_t      prev,
  output mkhm_pkg::cell_view_t view
);

  mkhm_pkg::byte_t data_r;
  logic            occ_r;
  mkhm_pkg::byte_t data_nxt;
  logic            occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (clear) begin
      occ_nxt = 1'b0;
    end else if (advance) begin
      data_nxt = prev.data;
      occ_nxt  = prev.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign view.data  = data_r;
  assign view.lower = mkhm_pkg::lower_ascii(data_r);
  assign view.space = (data_r == mkhm_pkg::SPACE_BYTE);
  assign view.occ   = occ_r;

endmodule

// ===== design/mkhm_rule.sv =====
module mkhm_rule #(
  parameter int KEY_BYTES = 8
) (
  input  logic [7:0]                   win_raw [KEY_BYTES+2],
  input  logic [7:0]                   win_low [KEY_BYTES+2],
  input  logic [KEY_BYTES+1:0]         win_space,
  input  logic [KEY_BYTES+1:0]         win_have,
  input  logic [mkhm_pkg::DATA_W-1:0]  keyword,
  input  logic [mkhm_pkg::CTL_W-1:0]   control,
  input  logic                         eom,
  output logic                         hit
);

  localparam int LENS = KEY_BYTES + 1;

  logic [3:0]      len_raw;
  logic            len_over;
  logic            cs;
  logic            whole;
  logic            en;
  logic [LENS-1:0] len_sel;
  logic [LENS-1:0] plain_hit;
  logic [LENS-1:0] eom_hit;
  logic [LENS-1:0] space_hit;

  assign len_raw  = control[mkhm_pkg::CTL_LEN_MSB:mkhm_pkg::CTL_LEN_LSB];
  assign len_over = (len_raw > 4'(KEY_BYTES));
  assign cs       = control[mkhm_pkg::CTL_CS_BIT];
  assign whole    = control[mkhm_pkg::CTL_WW_BIT];
  assign en       = control[mkhm_pkg::CTL_EN_BIT];

  // One candidate per keyword length; the control register picks one.
  for (genvar L = 0; L < LENS; L++) begin : g_len
    logic [KEY_BYTES-1:0] eq_cur;
    logic [KEY_BYTES-1:0] eq_prev;
    logic                 ge_cur;
    logic                 ex_cur;
    logic                 ge_prev;
    logic                 ex_prev;

    for (genvar k = 0; k < KEY_BYTES; k++) begin : g_byte
      if (k < L) begin : g_used
        // occurrence ending at the current byte, and ending one byte earlier
        assign eq_cur[k]  = mkhm_pkg::byte_match(win_raw[L-1-k], win_low[L-1-k],
                                                 keyword[8*k +: 8], cs);
        assign eq_prev[k] = mkhm_pkg::byte_match(win_raw[L-k], win_low[L-k],
                                                 keyword[8*k +: 8], cs);
      end else begin : g_unused
        assign eq_cur[k]  = 1'b1;
        assign eq_prev[k] = 1'b1;
      end
    end

    if (L == 0) begin : g_empty
      assign ge_cur = 1'b1;
      assign ex_cur = 1'b0;
    end else begin : g_nonempty
      assign ge_cur = win_have[L-1];
      assign ex_cur = win_have[L-1] & ~win_have[L];
    end
    assign ge_prev = win_have[L];
    assign ex_prev = win_have[L] & ~win_have[L+1];

    assign len_sel[L]   = len_over ? ((L == KEY_BYTES) ? 1'b1 : 1'b0) : (len_raw == 4'(L));
    assign plain_hit[L] = ge_cur & (&eq_cur);
    assign eom_hit[L]   = ge_cur & (&eq_cur) & (ex_cur | win_space[L]);
    assign space_hit[L] = win_space[0] & ge_prev & (&eq_prev) & (ex_prev | win_space[L+1]);
  end

  assign hit = en & (|(len_sel & (whole ? ((eom ? eom_hit : '0) | space_hit) : plain_hit)));

endmodule

// ===== design/multi_keyword_highlight_matcher.sv =====
// Keyword matcher for a byte stream.
// Input channel: one message byte per beat on in_tdata[7:0], in_tlast on the last
// byte of a message. Output channel: one beat per message, out_tdata[0] set when
// any enabled rule matched somewhere in that message.
// Rules are set through the APB port: keyword i at byte address 16*i, its control
// word (length, enable, case sensitive, whole word) at 16*i+8. Write them only
// while no message is in flight.
// The byte history is a chain of cells, one byte and one occupancy bit each,
// shifting by one every accepted beat but the last of a message, which clears
// it; all rules compare against the current byte plus the chain in the same cycle.
// Throughput: one byte per cycle across message boundaries while no result waits.
// Latency: the result beat is valid the cycle after the last byte is accepted.
// While a result beat waits for out_tready, in_tready stays low, so the input
// holds until the result is taken. Reset clears the chain, the match latch, the
// output valid flag and all rule registers (rules disabled); the block takes bytes
// right after reset.
`include "multi_keyword_highlight_matcher_assert.svh"

module multi_keyword_highlight_matcher #(
  parameter int RULE_COUNT = 4,
  parameter int KEY_BYTES  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] text_byte
  input  logic                          in_tlast,   // end_of_message
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [0] highlight_found, [7:1] zero
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mkhm_pkg::ADDR_W-1:0]   paddr,
  input  logic [mkhm_pkg::DATA_W-1:0]   pwdata,
  output logic [mkhm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int HIST = KEY_BYTES + 1;
  localparam int WIN  = KEY_BYTES + 2;

  logic [mkhm_pkg::DATA_W-1:0] kw_r  [mkhm_pkg::RULE_SLOTS];
  logic [mkhm_pkg::CTL_W-1:0]  ctl_r [mkhm_pkg::RULE_SLOTS];

  logic                        cfg_wr;
  logic [1:0]                  cfg_rule;
  logic                        cfg_sel;

  logic                        in_fire;
  logic                        clear;
  logic                        advance;
  mkhm_pkg::cell_view_t        view [HIST];
  mkhm_pkg::cell_t             feed [HIST];
  logic [HIST-1:0]             occ_vec;

  logic [7:0]                  win_raw [WIN];
  logic [7:0]                  win_low [WIN];
  logic [WIN-1:0]              win_space;
  logic [WIN-1:0]              win_have;
  logic [RULE_COUNT-1:0]       rule_hit;
  logic                        any_hit;

  logic                        latch_r;
  logic                        latch_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        found_r;
  logic                        found_nxt;

  // ---------------- configuration ----------------
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_rule = paddr[5:4];
  assign cfg_sel  = paddr[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mkhm_pkg::RULE_SLOTS; i++) begin
        kw_r[i]  <= '0;
        ctl_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        mkhm_pkg::REG_SEL_KEYWORD: kw_r[cfg_rule]  <= pwdata;
        mkhm_pkg::REG_SEL_CONTROL: ctl_r[cfg_rule] <= pwdata[mkhm_pkg::CTL_W-1:0];
        default:                   kw_r[cfg_rule]  <= kw_r[cfg_rule];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      mkhm_pkg::REG_SEL_KEYWORD: prdata = kw_r[cfg_rule];
      mkhm_pkg::REG_SEL_CONTROL:
        prdata = {{(mkhm_pkg::DATA_W - mkhm_pkg::CTL_W){1'b0}}, ctl_r[cfg_rule]};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- history chain ----------------
  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;
  assign advance   = in_fire & ~in_tlast;
  assign clear     = in_fire & in_tlast;

  for (genvar i = 0; i < HIST; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign feed[i].data = in_tdata;
      assign feed[i].occ  = 1'b1;
    end else begin : g_link
      assign feed[i].data = view[i-1].data;
      assign feed[i].occ  = view[i-1].occ;
    end

    mkhm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .clear   (clear),
      .prev    (feed[i]),
      .view    (view[i])
    );

    assign occ_vec[i]        = view[i].occ;
    assign win_raw[i+1]      = view[i].data;
    assign win_low[i+1]      = view[i].lower;
    assign win_space[i+1]    = view[i].space;
    assign win_have[i+1]     = view[i].occ;
  end

  assign win_raw[0]   = in_tdata;
  assign win_low[0]   = mkhm_pkg::lower_ascii(in_tdata);
  assign win_space[0] = (in_tdata == mkhm_pkg::SPACE_BYTE);
  assign win_have[0]  = 1'b1;

  // ---------------- rule matchers ----------------
  for (genvar r = 0; r < RULE_COUNT; r++) begin : g_rule
    mkhm_rule #(
      .KEY_BYTES (KEY_BYTES)
    ) u_rule (
      .win_raw   (win_raw),
      .win_low   (win_low),
      .win_space (win_space),
      .win_have  (win_have),
      .keyword   (kw_r[r]),
      .control   (ctl_r[r]),
      .eom       (in_tlast),
      .hit       (rule_hit[r])
    );
  end

  assign any_hit = |rule_hit;

  // ---------------- match latch and result register ----------------
  always_comb begin
    latch_nxt     = latch_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      if (in_tlast) begin
        latch_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        found_nxt     = latch_r | any_hit;
      end else begin
        latch_nxt = latch_r | any_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      latch_r     <= latch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, found_r};

  // ---------------- assertions ----------------
  `MKHM_ASSERT_NEXT(a_eom_gives_result, clear, out_tvalid, "no result after last byte")
  `MKHM_ASSERT_NEXT(a_eom_clears, clear, !latch_r && (occ_vec == '0), "state not cleared")
  `MKHM_ASSERT_NEXT(a_byte_in, advance, occ_vec[0] && view[0].data == $past(in_tdata), "byte lost")
  `MKHM_ASSERT_ALWAYS(a_occ_thermometer, (occ_vec & (occ_vec + HIST'(1))) == '0, "occupancy gap")

endmodule
